FILE: hdl/kmrl_pkg.sv
// kmrl_pkg: types and constants for the key matrix return line block
// depends on nothing; used by kmrl_line_unit and key_matrix_return_lines_core
package kmrl_pkg;

  // widths
  localparam int unsigned MAP_W     = 32;
  localparam int unsigned CODE_W    = 8;
  localparam int unsigned K_W       = 4;
  localparam int unsigned PAD_W     = 4;
  localparam int unsigned BTN_W     = 12;
  localparam int unsigned STB_W     = 8;
  localparam int unsigned NUM_MAPS  = 8;
  localparam int unsigned MAP_IDX_W = 3;
  localparam int unsigned CFG_IDX_W = 4;

  // host button bit positions
  localparam int unsigned BTN_A_BIT      = 4;
  localparam int unsigned BTN_SOFT_TIME  = 10;
  localparam int unsigned BTN_SOFT_ALARM = 11;

  // button codes
  localparam logic [CODE_W-1:0] CODE_NONE       = 8'h00;
  localparam logic [CODE_W-1:0] CODE_SOFT_TIME  = 8'h60;
  localparam logic [CODE_W-1:0] CODE_SOFT_ALARM = 8'hA0;
  localparam logic [CODE_W-1:0] CODE_LEFT_UP    = 8'h03;
  localparam logic [CODE_W-1:0] CODE_LEFT_DOWN  = 8'h09;
  localparam logic [CODE_W-1:0] CODE_RIGHT_UP   = 8'h06;
  localparam logic [CODE_W-1:0] CODE_RIGHT_DOWN = 8'h0C;

  // d-pad values
  localparam logic [PAD_W-1:0] PAD_MASK  = 4'hF;
  localparam logic [PAD_W-1:0] PAD_LEFT  = 4'h1;
  localparam logic [PAD_W-1:0] PAD_UP    = 4'h2;
  localparam logic [PAD_W-1:0] PAD_RIGHT = 4'h4;
  localparam logic [PAD_W-1:0] PAD_DOWN  = 4'h8;
  localparam logic [PAD_W-1:0] PAD_VERT  = 4'hA;
  localparam logic [PAD_W-1:0] PAD_HORZ  = 4'h5;

  // zero strobe stands for line 1 alone
  localparam logic [STB_W-1:0] STROBE_DEFAULT = 8'h02;

  // working state carried from one strobe line to the next
  typedef struct packed {
    logic [CODE_W-1:0] keys;
    logic [PAD_W-1:0]  last_pad;
    logic              held;
  } kmrl_line_st_t;

endpackage

FILE: hdl/kmrl_line_unit.sv
// kmrl_line_unit: shared matcher, one strobe line per cycle unless
// stalled; classifies the map, matches its four codes; uses kmrl_pkg
module kmrl_line_unit (
  input  logic [kmrl_pkg::MAP_W-1:0]  map,
  input  logic                        line_en,
  input  logic [kmrl_pkg::CODE_W-1:0] soft_code,
  input  logic                        armed,
  input  kmrl_pkg::kmrl_line_st_t     st_in,
  output kmrl_pkg::kmrl_line_st_t     st_out,
  output logic [kmrl_pkg::K_W-1:0]    k_hit
);
  import kmrl_pkg::*;

  logic [CODE_W-1:0] code [K_W];
  logic              has_lu, has_ld, has_ru, has_rd;
  logic              is_diag;
  logic [PAD_W-1:0]  v;

  // split the map into its four codes
  always_comb begin
    for (int k = 0; k < K_W; k++) begin
      code[k] = map[k*CODE_W +: CODE_W];
    end
  end

  // a diagonal line holds all four diagonal codes
  always_comb begin
    has_lu = 1'b0;
    has_ld = 1'b0;
    has_ru = 1'b0;
    has_rd = 1'b0;
    for (int k = 0; k < K_W; k++) begin
      if (code[k] == CODE_LEFT_UP)    has_lu = 1'b1;
      if (code[k] == CODE_LEFT_DOWN)  has_ld = 1'b1;
      if (code[k] == CODE_RIGHT_UP)   has_ru = 1'b1;
      if (code[k] == CODE_RIGHT_DOWN) has_rd = 1'b1;
    end
    is_diag = has_lu & has_ld & has_ru & has_rd;
  end

  // per-line match
  always_comb begin
    st_out = st_in;
    k_hit  = '0;
    v      = st_in.keys[PAD_W-1:0];
    if (line_en) begin
      if (is_diag) begin
        // one-shot A toggle to the opposite diagonal
        if (armed && !st_in.held) begin
          st_out.held = 1'b1;
          v = ~st_in.last_pad & PAD_MASK;
        end
        // complete a lone direction from the last pad value
        if (v == PAD_LEFT || v == PAD_RIGHT) begin
          v = v | (st_in.last_pad & PAD_VERT);
        end else if (v == PAD_UP || v == PAD_DOWN) begin
          v = v | (st_in.last_pad & PAD_HORZ);
        end
        st_out.keys = {{(CODE_W-PAD_W){1'b0}}, v};
        for (int k = 0; k < K_W; k++) begin
          if (code[k] == {{(CODE_W-PAD_W){1'b0}}, v}) begin
            k_hit[k]        = 1'b1;
            st_out.last_pad = v;
          end
        end
      end else if (soft_code != CODE_NONE) begin
        for (int k = 0; k < K_W; k++) begin
          k_hit[k] = (code[k] == soft_code);
        end
      end else begin
        for (int k = 0; k < K_W; k++) begin
          k_hit[k] = ((code[k] & st_in.keys) != CODE_NONE) &&
                     (code[k] != CODE_SOFT_ALARM) && (code[k] != CODE_SOFT_TIME);
        end
      end
    end
  end

endmodule

FILE: hdl/key_matrix_return_lines_core.sv
// key_matrix_return_lines_core: top level of the key matrix return line emulation
// walks the strobe lines with kmrl_line_unit; uses kmrl_pkg
//
//  channel | direction | handshake             | beat contents
//  in      | slave     | in_tvalid / in_tready | host_buttons, strobe_lines
//  out     | master    | out_tvalid/out_tready | k_lines
//  cfg     | slave     | cfg_valid / cfg_ready | key map index, key map word
//
// an item is taken in ST_IDLE, then walked one strobe line per cycle through
// the shared line unit in ST_WALK; out_tvalid rises once the last line's
// result is loaded into the output register.
// in_tready is high only while idle. a result that is not taken holds the
// walk on its last line. rst_n clears the key maps, the pad state and control.
// configuration writes are taken in every cycle.
module key_matrix_return_lines_core #(
  parameter int unsigned STROBE_COUNT = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // [11:0] host_buttons, [19:12] strobe_lines, [23:20] zero
  input  logic [23:0]                    in_tdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [3:0] k_lines, [7:4] zero
  output logic [7:0]                     out_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [kmrl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kmrl_pkg::MAP_W-1:0]     cfg_data
);
  import kmrl_pkg::*;

  localparam int unsigned LINE_W = (STROBE_COUNT > 1) ? $clog2(STROBE_COUNT) : 1;
  localparam logic [LINE_W-1:0] LAST_LINE = LINE_W'(STROBE_COUNT - 1);

  typedef enum logic {ST_IDLE, ST_WALK} state_t;

  state_t            state_r;
  logic [LINE_W-1:0] line_r;
  logic [STB_W-1:0]  strobe_r;
  logic [CODE_W-1:0] soft_r;
  logic              armed_r;
  kmrl_line_st_t     st_r;
  logic [K_W-1:0]    k_r;
  logic [K_W-1:0]    out_k_r;
  logic              out_valid_r;
  logic [MAP_W-1:0]  key_map_r [NUM_MAPS];

  logic [BTN_W-1:0]     btn;
  logic [STB_W-1:0]     strobe_in;
  logic [CODE_W-1:0]    keys_nxt;
  logic [CODE_W-1:0]    soft_nxt;
  logic                 armed_nxt;
  logic [STB_W-1:0]     strobe_nxt;
  logic [MAP_IDX_W-1:0] map_idx;
  kmrl_line_st_t        st_unit;
  logic [K_W-1:0]       k_hit;
  logic [K_W-1:0]       k_all;
  logic                 walk_end;
  logic                 out_load;

  assign btn       = in_tdata[BTN_W-1:0];
  assign strobe_in = in_tdata[BTN_W +: STB_W];

  // soft key selection, A tracking and strobe fix-up of the incoming beat
  always_comb begin
    keys_nxt = btn[CODE_W-1:0];
    soft_nxt = CODE_NONE;
    if (btn[BTN_SOFT_TIME]) begin
      keys_nxt = CODE_NONE;
      soft_nxt = CODE_SOFT_TIME;
    end
    if (btn[BTN_SOFT_ALARM]) begin
      keys_nxt = CODE_NONE;
      soft_nxt = CODE_SOFT_ALARM;
    end
    if (keys_nxt == CODE_SOFT_ALARM) begin
      soft_nxt = CODE_SOFT_ALARM;
      keys_nxt = CODE_NONE;
    end
    if (keys_nxt == CODE_SOFT_TIME) begin
      soft_nxt = CODE_SOFT_TIME;
      keys_nxt = CODE_NONE;
    end
    armed_nxt = keys_nxt[BTN_A_BIT];
    // nothing pressed enables no line and answers zero
    if (keys_nxt == CODE_NONE && soft_nxt == CODE_NONE) begin
      strobe_nxt = '0;
    end else if (strobe_in == '0) begin
      strobe_nxt = STROBE_DEFAULT;
    end else begin
      strobe_nxt = strobe_in;
    end
  end

  // current line feeds the shared unit
  assign map_idx = MAP_IDX_W'(line_r);

  kmrl_line_unit u_line (
    .map       (key_map_r[map_idx]),
    .line_en   (strobe_r[map_idx]),
    .soft_code (soft_r),
    .armed     (armed_r),
    .st_in     (st_r),
    .st_out    (st_unit),
    .k_hit     (k_hit)
  );

  assign k_all    = k_r | k_hit;
  assign walk_end = (line_r == LAST_LINE) && (!out_valid_r || out_tready);
  assign out_load = (state_r == ST_WALK) && walk_end;

  // sequencer, working state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      line_r      <= '0;
      strobe_r    <= '0;
      soft_r      <= CODE_NONE;
      armed_r     <= 1'b0;
      st_r        <= '0;
      k_r         <= '0;
      out_k_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // a beat taken in the cycle that loads the next one keeps valid high
      if (out_valid_r && out_tready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            line_r      <= '0;
            strobe_r    <= strobe_nxt;
            soft_r      <= soft_nxt;
            armed_r     <= armed_nxt;
            st_r.keys   <= keys_nxt;
            st_r.held   <= armed_nxt & st_r.held;
            k_r         <= '0;
            state_r     <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (line_r != LAST_LINE) begin
            st_r   <= st_unit;
            k_r    <= k_all;
            line_r <= line_r + 1'b1;
          end else if (walk_end) begin
            st_r        <= st_unit;
            out_k_r     <= k_all;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // key map registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_MAPS; i++) begin
        key_map_r[i] <= '0;
      end
    end else if (cfg_valid && (cfg_index < CFG_IDX_W'(NUM_MAPS))) begin
      key_map_r[cfg_index[MAP_IDX_W-1:0]] <= cfg_data;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(8-K_W){1'b0}}, out_k_r};

endmodule

FILE: dv/tb_key_matrix_return_lines_core.sv
// tb_key_matrix_return_lines_core: self-checking bench for the key matrix return line core
// drives button/strobe beats and key map writes, predicts k_lines per beat and compares
// depends on kmrl_pkg and key_matrix_return_lines_core
`timescale 1ns / 1ps

module tb_key_matrix_return_lines_core;
  import kmrl_pkg::*;

  localparam int ITEM_LATENCY    = NUM_MAPS + 1;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int NUM_ROWS        = 24;
  localparam int FIRST_MAPPED    = 3;
  localparam int NUM_SETUPS      = 10;
  localparam int BEATS_PER_SETUP = 100;
  localparam int CFG_IDX_TOP     = (1 << CFG_IDX_W) - 1;

  typedef struct packed {
    logic [BTN_W-1:0] buttons;
    logic [STB_W-1:0] strobe;
    logic             typed;
    logic [K_W-1:0]   k_lines;
  } key_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic [23:0] in_tdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [7:0] out_tdata;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [MAP_W-1:0] cfg_data = '0;

  // predictor copy of key maps and pad state
  logic [MAP_W-1:0] key_map_copy [NUM_MAPS];
  logic [PAD_W-1:0] pad_last = '0;
  logic a_armed = 1'b0;
  logic a_held = 1'b0;

  logic [K_W-1:0] k_lines_due [$];
  key_row_t directed_rows [NUM_ROWS];
  logic [MAP_W-1:0] directed_maps [NUM_MAPS];

  bit quiet = 1'b0;
  int mismatches = 0;
  int beats_sent = 0;
  int results_seen = 0;
  int cfg_writes = 0;
  int stall_left = 0;
  int idle_cycles = 0;
  int out_gap;
  logic [K_W-1:0] k_want;

  key_matrix_return_lines_core #(.STROBE_COUNT(NUM_MAPS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // mostly short gaps, a few long ones, none in quiet stretches
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic map_holds(logic [MAP_W-1:0] m, logic [CODE_W-1:0] c);
    for (int j = 0; j < 4; j++)
      if (m[CODE_W*j +: CODE_W] == c) return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic dpad_line(logic [MAP_W-1:0] m);
    return map_holds(m, CODE_LEFT_UP) && map_holds(m, CODE_LEFT_DOWN) &&
           map_holds(m, CODE_RIGHT_UP) && map_holds(m, CODE_RIGHT_DOWN);
  endfunction

  // expected k_lines for one beat; updates the pad state
  function automatic logic [K_W-1:0] predict_k_lines(logic [BTN_W-1:0] b, logic [STB_W-1:0] s);
    logic [CODE_W-1:0] keys, soft_key, code;
    logic [STB_W-1:0] stb;
    logic [MAP_W-1:0] m;
    logic [K_W-1:0] k;
    keys = b[CODE_W-1:0];
    soft_key = CODE_NONE;
    k = '0;
    if (b[BTN_SOFT_TIME]) begin
      keys = CODE_NONE;
      soft_key = CODE_SOFT_TIME;
    end
    if (b[BTN_SOFT_ALARM]) begin
      keys = CODE_NONE;
      soft_key = CODE_SOFT_ALARM;
    end
    if (keys == CODE_SOFT_ALARM) begin
      soft_key = CODE_SOFT_ALARM;
      keys = CODE_NONE;
    end
    if (keys == CODE_SOFT_TIME) begin
      soft_key = CODE_SOFT_TIME;
      keys = CODE_NONE;
    end
    // A tracking happens on every beat
    if (keys[BTN_A_BIT]) begin
      a_armed = 1'b1;
    end else begin
      a_armed = 1'b0;
      a_held = 1'b0;
    end
    if (keys == CODE_NONE && soft_key == CODE_NONE) return '0;
    stb = (s == '0) ? STROBE_DEFAULT : s;
    for (int ln = 0; ln < NUM_MAPS; ln++) begin
      if (stb[ln]) begin
        m = key_map_copy[ln];
        if (dpad_line(m)) begin
          keys = keys & {4'h0, PAD_MASK};
          // one-shot jump to the opposite diagonal on a fresh A
          if (a_armed && !a_held) begin
            a_held = 1'b1;
            keys = {4'h0, ~pad_last};
          end
          if (keys == {4'h0, PAD_LEFT} || keys == {4'h0, PAD_RIGHT})
            keys = keys | {4'h0, pad_last & PAD_VERT};
          else if (keys == {4'h0, PAD_UP} || keys == {4'h0, PAD_DOWN})
            keys = keys | {4'h0, pad_last & PAD_HORZ};
          for (int j = 0; j < 4; j++)
            if (m[CODE_W*j +: CODE_W] == keys) begin
              k[j] = 1'b1;
              pad_last = keys[PAD_W-1:0];
            end
        end else if (soft_key != CODE_NONE) begin
          for (int j = 0; j < 4; j++)
            if (m[CODE_W*j +: CODE_W] == soft_key) k[j] = 1'b1;
        end else begin
          for (int j = 0; j < 4; j++) begin
            code = m[CODE_W*j +: CODE_W];
            if ((code & keys) != '0 && code != CODE_SOFT_ALARM && code != CODE_SOFT_TIME)
              k[j] = 1'b1;
          end
        end
      end
    end
    return k;
  endfunction

  // key map: mostly d-pad lines, near misses, random words, soft codes, extremes
  function automatic logic [MAP_W-1:0] random_key_map();
    logic [CODE_W-1:0] codes [4];
    logic [CODE_W-1:0] t;
    logic [MAP_W-1:0] m;
    int a, r;
    codes[0] = CODE_LEFT_UP;
    codes[1] = CODE_LEFT_DOWN;
    codes[2] = CODE_RIGHT_UP;
    codes[3] = CODE_RIGHT_DOWN;
    for (int j = 3; j > 0; j--) begin
      a = $urandom_range(0, j);
      t = codes[j];
      codes[j] = codes[a];
      codes[a] = t;
    end
    m = {codes[3], codes[2], codes[1], codes[0]};
    r = $urandom_range(0, 7);
    case (r)
      3: m[CODE_W*$urandom_range(0, 3) +: CODE_W] = CODE_W'($urandom_range(0, 255));
      4: m = $urandom;
      5: begin
        for (int j = 0; j < 4; j++)
          case ($urandom_range(0, 3))
            0: m[CODE_W*j +: CODE_W] = CODE_SOFT_TIME;
            1: m[CODE_W*j +: CODE_W] = CODE_SOFT_ALARM;
            2: m[CODE_W*j +: CODE_W] = 8'h01 << $urandom_range(0, 7);
            default: m[CODE_W*j +: CODE_W] = CODE_W'($urandom_range(0, 255));
          endcase
      end
      6: m = '0;
      7: m = '1;
      default: ;
    endcase
    return m;
  endfunction

  // beat: half d-pad presses, some with A, then soft keys, empty and noise
  function automatic logic [STB_W+BTN_W-1:0] random_beat();
    logic [BTN_W-1:0] b;
    logic [STB_W-1:0] s;
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) begin
      case ($urandom_range(0, 3))
        0: b = 12'h001 << $urandom_range(0, 3);
        1: b = {4'h0, CODE_LEFT_UP} << ($urandom_range(0, 1) * 2);
        2: b = $urandom_range(0, 1) ? {4'h0, CODE_LEFT_DOWN} : {4'h0, CODE_RIGHT_UP};
        default: b = BTN_W'($urandom_range(0, 15));
      endcase
      if ($urandom_range(0, 9) < 4) b[BTN_A_BIT] = 1'b1;
      if ($urandom_range(0, 4) == 0) b[9:8] = 2'($urandom_range(0, 3));
    end else if (r == 5) begin
      case ($urandom_range(0, 3))
        0: b = 12'h1 << BTN_SOFT_TIME;
        1: b = 12'h1 << BTN_SOFT_ALARM;
        2: b = {4'h0, CODE_SOFT_TIME};
        default: b = {4'h0, CODE_SOFT_ALARM};
      endcase
      if (b[CODE_W-1:0] == CODE_NONE) b[9:0] = 10'($urandom_range(0, 1023));
    end else if (r == 6) begin
      b = $urandom_range(0, 1) ? 12'h000 : 12'h300;
    end else begin
      b = BTN_W'($urandom_range(0, 4095));
    end
    r = $urandom_range(0, 9);
    if (r == 0) s = '0;
    else if (r < 4) s = 8'h01 << $urandom_range(0, 7);
    else s = STB_W'($urandom_range(0, 255));
    return {s, b};
  endfunction

  task automatic report_mismatch(string what, logic [K_W-1:0] want, logic [K_W-1:0] got);
    $display("mismatch at result %0d: %s expected %h got %h", results_seen, what, want, got);
    mismatches++;
  endtask

  // one input beat; the expectation is queued at the accepting edge
  task automatic send_beat(logic [BTN_W-1:0] b, logic [STB_W-1:0] s,
                           logic typed = 1'b0, logic [K_W-1:0] k = '0);
    int gap;
    logic [K_W-1:0] k_pred;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'h0, s, b};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    k_pred = predict_k_lines(b, s);
    k_lines_due.push_back(typed ? k : k_pred);
    beats_sent++;
  endtask

  task automatic write_key_map(logic [CFG_IDX_W-1:0] idx, logic [MAP_W-1:0] word);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= word;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    // indexes past the last map are dropped
    if (idx < NUM_MAPS) key_map_copy[idx[MAP_IDX_W-1:0]] = word;
    cfg_writes++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (k_lines_due.size() != 0) @(posedge clk);
    repeat (ITEM_LATENCY) @(posedge clk);
  endtask

  // result check and receiver stalls
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (k_lines_due.size() == 0) begin
        report_mismatch("unexpected beat, k_lines", '0, out_tdata[K_W-1:0]);
      end else begin
        k_want = k_lines_due.pop_front();
        if (out_tdata[K_W-1:0] !== k_want)
          report_mismatch("k_lines", k_want, out_tdata[K_W-1:0]);
      end
      results_seen++;
    end
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else begin
      out_gap = pick_gap();
      out_tready <= (out_gap == 0);
      if (out_gap > 0) stall_left = out_gap - 1;
    end
  end

  // watchdog on cycles with no handshake on any channel
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
      $display("key_matrix_return_lines_core regression: fail");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < NUM_MAPS; i++) key_map_copy[i] = '0;

    // d-pad line, soft/plain line, high buttons, all ones, singles, empty,
    // near-miss d-pad, reversed d-pad
    directed_maps[0] = 32'h0C060903;
    directed_maps[1] = 32'hA0601001;
    directed_maps[2] = 32'h80402010;
    directed_maps[3] = 32'hFFFFFFFF;
    directed_maps[4] = 32'h08040201;
    directed_maps[5] = 32'h00000000;
    directed_maps[6] = 32'h0C06090A;
    directed_maps[7] = 32'h0306090C;

    // maps at reset value: nothing can match
    directed_rows[0]  = '{12'hFFF, 8'hFF, 1'b1, 4'h0};
    directed_rows[1]  = '{12'h0FF, 8'h00, 1'b1, 4'h0};
    directed_rows[2]  = '{12'h000, 8'hFF, 1'b1, 4'h0};
    // nothing pressed, with and without the ignored bits
    directed_rows[3]  = '{12'h000, 8'hFF, 1'b1, 4'h0};
    directed_rows[4]  = '{12'h300, 8'hFF, 1'b1, 4'h0};
    // diagonal, single-axis completion, A toggle then held
    directed_rows[5]  = '{12'h003, 8'h01, 1'b0, 4'h0};
    directed_rows[6]  = '{12'h001, 8'h01, 1'b0, 4'h0};
    directed_rows[7]  = '{12'h008, 8'h01, 1'b0, 4'h0};
    directed_rows[8]  = '{12'h013, 8'h01, 1'b0, 4'h0};
    directed_rows[9]  = '{12'h013, 8'h01, 1'b0, 4'h0};
    directed_rows[10] = '{12'h010, 8'h01, 1'b0, 4'h0};
    // soft keys by request bits and by exact codes, zero strobe
    directed_rows[11] = '{12'h400, 8'h00, 1'b0, 4'h0};
    directed_rows[12] = '{12'h800, 8'h02, 1'b0, 4'h0};
    directed_rows[13] = '{12'hC00, 8'h02, 1'b0, 4'h0};
    directed_rows[14] = '{12'h060, 8'hFF, 1'b0, 4'h0};
    directed_rows[15] = '{12'h0A0, 8'hFF, 1'b0, 4'h0};
    // plain lines, extremes, mixed d-pad lines in one beat
    directed_rows[16] = '{12'h020, 8'h04, 1'b0, 4'h0};
    directed_rows[17] = '{12'h080, 8'h08, 1'b0, 4'h0};
    directed_rows[18] = '{12'h00F, 8'h81, 1'b0, 4'h0};
    directed_rows[19] = '{12'h0FF, 8'hFF, 1'b0, 4'h0};
    directed_rows[20] = '{12'hFFF, 8'hFF, 1'b0, 4'h0};
    directed_rows[21] = '{12'h004, 8'h00, 1'b0, 4'h0};
    directed_rows[22] = '{12'h00C, 8'h40, 1'b0, 4'h0};
    directed_rows[23] = '{12'h005, 8'h10, 1'b0, 4'h0};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (int i = 0; i < NUM_ROWS; i++) begin
      if (i == FIRST_MAPPED) begin
        drain();
        for (int ln = 0; ln < NUM_MAPS; ln++)
          write_key_map(CFG_IDX_W'(ln), directed_maps[ln]);
        cfg_valid <= 1'b0;
      end
      send_beat(directed_rows[i].buttons, directed_rows[i].strobe,
                directed_rows[i].typed, directed_rows[i].k_lines);
    end

    // random setups: all ones, all zeros, then mixed maps
    for (int p = 0; p < NUM_SETUPS; p++) begin
      drain();
      for (int ln = 0; ln < NUM_MAPS; ln++)
        write_key_map(CFG_IDX_W'(ln), (p == 0) ? '1 : (p == 1) ? '0 : random_key_map());
      repeat ($urandom_range(0, 2))
        write_key_map(CFG_IDX_W'($urandom_range(NUM_MAPS, CFG_IDX_TOP)), $urandom);
      cfg_valid <= 1'b0;
      quiet = (p % 4 == 3);
      for (int n = 0; n < BEATS_PER_SETUP; n++) begin
        logic [STB_W+BTN_W-1:0] beat;
        beat = random_beat();
        send_beat(beat[BTN_W-1:0], beat[STB_W+BTN_W-1:BTN_W]);
      end
    end

    drain();
    repeat (2 * ITEM_LATENCY) @(posedge clk);
    $display("covered %0d input beats and %0d results over %0d key map setups (%0d writes)",
             beats_sent, results_seen, NUM_SETUPS + 1, cfg_writes);
    $display("mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("key_matrix_return_lines_core regression: pass");
    end else begin
      $display("key_matrix_return_lines_core regression: fail");
    end
    $finish;
  end

endmodule
